FILE: rtl/mpa_pkg.sv
// Package with the beat types and the kind and status codes of the multi-pattern automaton.
package mpa_pkg;

  localparam int NODE_W = 10;
  localparam int KIND_W = 3;
  localparam int SYM_W  = 7;
  localparam int STAT_W = 2;

  localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_END    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_BUILD  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MATCH  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RESET  = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_SYM   = 2'd2;
  localparam logic [STAT_W-1:0] STAT_PHASE = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SYM_W-1:0]  symbol;
  } in_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic              matched;
    logic [STAT_W-1:0] status;
  } out_t;

endpackage

FILE: rtl/multi_pattern_automaton.sv
// Top level of the multi-pattern automaton: trie build, link pass and matching over memories.
//
// Items are taken on start while busy is low, and every item gives exactly one result beat,
// shown for one cycle on out_valid; the receiver cannot hold results off, so it must take
// each beat as it comes. End-pattern items, items in the wrong phase, unknown kinds, inserts
// with a bad symbol and a reset-match before the build are answered straight from idle. An
// insert passes through a check state, and when a node is allocated through a clearing
// state as well (the child-bit memory has one write port, so the new node's row is cleared
// in a state of its own). A match after the build reads the transition memory, then the
// terminal-flag memory. A reset-match after the build, or a match with a bad symbol, reads
// only the terminal-flag memory. The build pass handles the root and then every other node
// taken from the breadth-first queue, reading its queue entry, failure link and terminal
// flag first, and ends when it finds the queue empty. Each symbol needs a read of the
// transition memory and then a write back, and that one memory sets the length of the pass.
// After reset the block is busy while it clears the root's entries. The configuration
// channel is always ready; writes after the build are ignored, and values are clamped into
// 1 to MAX_ALPHABET.
module multi_pattern_automaton #(
  parameter int MAX_NODES    = 1024,
  parameter int MAX_ALPHABET = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  mpa_pkg::in_t  in_data,
  output logic          out_valid,
  output mpa_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [6:0]    cfg_data
);
  import mpa_pkg::*;

  localparam int NW = $clog2(MAX_NODES);
  localparam int AW = $clog2(MAX_ALPHABET);
  localparam int GW = NW + AW;
  localparam int LW = $clog2(MAX_ALPHABET + 1);
  localparam int CW = (LW > SYM_W) ? LW : SYM_W;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_INS_CHK, S_INS_CLR, S_MT_GO, S_MT_TERM,
    S_B_ROOT, S_Q_RD, S_Q_WAIT, S_F_WAIT, S_T_WAIT, S_S_RD, S_S_WR
  } state_t;

  // Memories: transitions (two read ports), child bits per node, terminal flags,
  // failure links and the breadth-first queue.
  logic [NW-1:0]           goto_mem [0:(1<<GW)-1];
  logic [MAX_ALPHABET-1:0] child_mem [0:(1<<NW)-1];
  logic                    term_mem [0:(1<<NW)-1];
  logic [NW-1:0]           fail_mem [0:(1<<NW)-1];
  logic [NW-1:0]           queue_mem [0:(1<<NW)-1];

  logic [GW-1:0] go_ra, go_rb, go_wa;
  logic [NW-1:0] go_wd, go_a_q, go_b_q;
  logic          go_we;
  logic [NW-1:0] ch_ra, ch_wa;
  logic [MAX_ALPHABET-1:0] ch_wd, ch_q;
  logic          ch_we;
  logic [NW-1:0] tm_ra, tm_wa;
  logic          tm_wd, tm_we, tm_q;
  logic [NW-1:0] fl_ra, fl_wa, fl_wd, fl_q;
  logic          fl_we;
  logic [NW-1:0] q_ra, q_wa, q_wd, q_q;
  logic          q_we;

  always_ff @(posedge clk) begin
    if (go_we) begin
      goto_mem[go_wa] <= go_wd;
    end
    go_a_q <= goto_mem[go_ra];
    go_b_q <= goto_mem[go_rb];
  end

  always_ff @(posedge clk) begin
    if (ch_we) begin
      child_mem[ch_wa] <= ch_wd;
    end
    ch_q <= child_mem[ch_ra];
  end

  always_ff @(posedge clk) begin
    if (tm_we) begin
      term_mem[tm_wa] <= tm_wd;
    end
    tm_q <= term_mem[tm_ra];
  end

  always_ff @(posedge clk) begin
    if (fl_we) begin
      fail_mem[fl_wa] <= fl_wd;
    end
    fl_q <= fail_mem[fl_ra];
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      queue_mem[q_wa] <= q_wd;
    end
    q_q <= queue_mem[q_ra];
  end

  // Control state.
  state_t          state_r, state_nxt;
  logic [NW-1:0]   cursor_r, cursor_nxt;
  logic [NW-1:0]   mstate_r, mstate_nxt;
  logic [NW:0]     count_r, count_nxt;
  logic            built_r, built_nxt;
  logic [LW-1:0]   alph_r, alph_nxt;
  logic            out_valid_r, out_valid_nxt;

  // Working registers of the insert, match and build sequences.
  out_t            out_r, out_nxt;
  logic [AW-1:0]   sidx_r, sidx_nxt;
  logic [NW-1:0]   now_r, now_nxt;
  logic [NW-1:0]   fnode_r, fnode_nxt;
  logic [MAX_ALPHABET-1:0] row_r, row_nxt;
  logic            root_r, root_nxt;
  logic [NW:0]     head_r, head_nxt;
  logic [NW:0]     tail_r, tail_nxt;
  logic [STAT_W-1:0] stat_r, stat_nxt;

  logic [SYM_W-1:0] sym_m1;
  logic [AW-1:0]    in_sidx;
  logic             sym_ok;
  logic             accept;
  logic             last_sym;
  logic [NW-1:0]    fallback;
  logic [MAX_ALPHABET-1:0] sym_bit;
  logic [CW-1:0]    cfg_ext;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign sym_m1   = in_data.symbol - SYM_W'(1);
  assign in_sidx  = AW'(sym_m1);
  assign sym_ok   = (in_data.symbol != '0) && (CW'(in_data.symbol) <= CW'(alph_r));
  assign last_sym = (CW'(sidx_r) + CW'(1)) == CW'(alph_r);
  // Root transitions and first-level failure links point back at the root.
  assign fallback = root_r ? '0 : go_b_q;
  assign sym_bit  = {{(MAX_ALPHABET-1){1'b0}}, 1'b1} << sidx_r;
  assign cfg_ext  = CW'(cfg_data);

  always_comb begin
    state_nxt     = state_r;
    cursor_nxt    = cursor_r;
    mstate_nxt    = mstate_r;
    count_nxt     = count_r;
    built_nxt     = built_r;
    alph_nxt      = alph_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    sidx_nxt      = sidx_r;
    now_nxt       = now_r;
    fnode_nxt     = fnode_r;
    row_nxt       = row_r;
    root_nxt      = root_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    stat_nxt      = stat_r;

    go_ra = {cursor_r, in_sidx};
    go_rb = {fnode_r, sidx_r};
    go_we = 1'b0;
    go_wa = {now_r, sidx_r};
    go_wd = fallback;
    ch_ra = cursor_r;
    ch_we = 1'b0;
    ch_wa = cursor_r;
    ch_wd = '0;
    tm_ra = mstate_r;
    tm_we = 1'b0;
    tm_wa = cursor_r;
    tm_wd = 1'b0;
    fl_ra = q_q;
    fl_we = 1'b0;
    fl_wa = go_a_q;
    fl_wd = fallback;
    q_ra  = head_r[NW-1:0];
    q_we  = 1'b0;
    q_wa  = tail_r[NW-1:0];
    q_wd  = go_a_q;

    if (cfg_valid && !built_r) begin
      if (cfg_data == '0) begin
        alph_nxt = LW'(1);
      end else if (cfg_ext > CW'(MAX_ALPHABET)) begin
        alph_nxt = LW'(MAX_ALPHABET);
      end else begin
        alph_nxt = LW'(cfg_data);
      end
    end

    case (state_r)
      S_INIT: begin
        ch_we     = 1'b1;
        ch_wa     = '0;
        tm_we     = 1'b1;
        tm_wa     = '0;
        state_nxt = S_IDLE;
      end

      S_IDLE: begin
        if (accept) begin
          out_nxt.node    = '0;
          out_nxt.matched = 1'b0;
          out_nxt.status  = STAT_OK;
          sidx_nxt        = in_sidx;
          case (in_data.kind)
            KIND_INSERT: begin
              out_nxt.node = NODE_W'(cursor_r);
              if (built_r) begin
                out_nxt.status = STAT_PHASE;
                out_valid_nxt  = 1'b1;
              end else if (!sym_ok) begin
                out_nxt.status = STAT_SYM;
                out_valid_nxt  = 1'b1;
              end else begin
                state_nxt = S_INS_CHK;
              end
            end
            KIND_END: begin
              out_nxt.node  = NODE_W'(cursor_r);
              out_valid_nxt = 1'b1;
              if (built_r) begin
                out_nxt.status = STAT_PHASE;
              end else begin
                tm_we      = 1'b1;
                tm_wa      = cursor_r;
                tm_wd      = 1'b1;
                cursor_nxt = '0;
              end
            end
            KIND_BUILD: begin
              if (built_r) begin
                out_nxt.status = STAT_PHASE;
                out_valid_nxt  = 1'b1;
              end else begin
                ch_ra     = '0;
                head_nxt  = '0;
                tail_nxt  = '0;
                state_nxt = S_B_ROOT;
              end
            end
            KIND_MATCH: begin
              out_nxt.node = NODE_W'(mstate_r);
              if (!built_r) begin
                out_nxt.status = STAT_PHASE;
                out_valid_nxt  = 1'b1;
              end else if (!sym_ok) begin
                stat_nxt  = STAT_SYM;
                tm_ra     = mstate_r;
                state_nxt = S_MT_TERM;
              end else begin
                stat_nxt  = STAT_OK;
                go_ra     = {mstate_r, in_sidx};
                state_nxt = S_MT_GO;
              end
            end
            KIND_RESET: begin
              mstate_nxt = '0;
              if (built_r) begin
                stat_nxt  = STAT_OK;
                tm_ra     = '0;
                state_nxt = S_MT_TERM;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            default: begin
              out_nxt.status = STAT_PHASE;
              out_valid_nxt  = 1'b1;
            end
          endcase
        end
      end

      S_INS_CHK: begin
        if ((ch_q & sym_bit) != '0) begin
          cursor_nxt    = go_a_q;
          out_nxt.node  = NODE_W'(go_a_q);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (count_r >= (NW+1)'(MAX_NODES)) begin
          out_nxt.status = STAT_FULL;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          go_we      = 1'b1;
          go_wa      = {cursor_r, sidx_r};
          go_wd      = count_r[NW-1:0];
          ch_we      = 1'b1;
          ch_wa      = cursor_r;
          ch_wd      = ch_q | sym_bit;
          tm_we      = 1'b1;
          tm_wa      = count_r[NW-1:0];
          tm_wd      = 1'b0;
          cursor_nxt = count_r[NW-1:0];
          count_nxt  = count_r + (NW+1)'(1);
          state_nxt  = S_INS_CLR;
        end
      end

      S_INS_CLR: begin
        // The new node starts with no children.
        ch_we         = 1'b1;
        ch_wa         = cursor_r;
        ch_wd         = '0;
        out_nxt.node  = NODE_W'(cursor_r);
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      S_MT_GO: begin
        mstate_nxt = go_a_q;
        tm_ra      = go_a_q;
        state_nxt  = S_MT_TERM;
      end

      S_MT_TERM: begin
        out_nxt.node    = NODE_W'(mstate_r);
        out_nxt.matched = tm_q;
        out_nxt.status  = stat_r;
        out_valid_nxt   = 1'b1;
        state_nxt       = S_IDLE;
      end

      S_B_ROOT: begin
        row_nxt   = ch_q;
        now_nxt   = '0;
        fnode_nxt = '0;
        root_nxt  = 1'b1;
        sidx_nxt  = '0;
        state_nxt = S_S_RD;
      end

      S_Q_RD: begin
        if (head_r == tail_r) begin
          built_nxt     = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          q_ra      = head_r[NW-1:0];
          state_nxt = S_Q_WAIT;
        end
      end

      S_Q_WAIT: begin
        now_nxt   = q_q;
        fl_ra     = q_q;
        ch_ra     = q_q;
        head_nxt  = head_r + (NW+1)'(1);
        state_nxt = S_F_WAIT;
      end

      S_F_WAIT: begin
        fnode_nxt = fl_q;
        row_nxt   = ch_q;
        tm_ra     = fl_q;
        state_nxt = S_T_WAIT;
      end

      S_T_WAIT: begin
        // A node ends a pattern if its failure target does.
        if (tm_q) begin
          tm_we = 1'b1;
          tm_wa = now_r;
          tm_wd = 1'b1;
        end
        sidx_nxt  = '0;
        state_nxt = S_S_RD;
      end

      S_S_RD: begin
        go_ra     = {now_r, sidx_r};
        go_rb     = {fnode_r, sidx_r};
        state_nxt = S_S_WR;
      end

      S_S_WR: begin
        if (!row_r[sidx_r]) begin
          go_we = 1'b1;
          go_wa = {now_r, sidx_r};
          go_wd = fallback;
        end else begin
          fl_we = 1'b1;
          fl_wa = go_a_q;
          fl_wd = fallback;
          if (tail_r < (NW+1)'(MAX_NODES)) begin
            q_we     = 1'b1;
            q_wa     = tail_r[NW-1:0];
            q_wd     = go_a_q;
            tail_nxt = tail_r + (NW+1)'(1);
          end
        end
        if (last_sym) begin
          root_nxt  = 1'b0;
          state_nxt = S_Q_RD;
        end else begin
          sidx_nxt  = sidx_r + AW'(1);
          state_nxt = S_S_RD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    out_r   <= out_nxt;
    sidx_r  <= sidx_nxt;
    now_r   <= now_nxt;
    fnode_r <= fnode_nxt;
    row_r   <= row_nxt;
    root_r  <= root_nxt;
    head_r  <= head_nxt;
    tail_r  <= tail_nxt;
    stat_r  <= stat_nxt;
    if (!rst_n) begin
      state_r     <= S_INIT;
      cursor_r    <= '0;
      mstate_r    <= '0;
      count_r     <= (NW+1)'(1);
      built_r     <= 1'b0;
      alph_r      <= LW'(MAX_ALPHABET);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      mstate_r    <= mstate_nxt;
      count_r     <= count_nxt;
      built_r     <= built_nxt;
      alph_r      <= alph_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: rtl/mpa_checker.sv
// Port checker for the multi-pattern automaton, bound to the top level.
module mpa_port_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input mpa_pkg::out_t out_data,
  input logic          out_valid
);
  import mpa_pkg::*;

  // An accepted item either answers at once or keeps the block busy.
  a_accept_answers: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> out_valid || busy)
    else $error("accepted item neither answered nor started work");

  // A result beat is only shown once the block is free again.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat while busy");

  // Inserts never report a match, so a full table never comes with one.
  a_full_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == STAT_FULL |-> !out_data.matched)
    else $error("table full result carries a match");

endmodule

bind multi_pattern_automaton mpa_port_checker u_mpa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_data  (out_data),
  .out_valid (out_valid)
);
